[rtl/core/pqs_pkg.sv]
// Types and constants shared by the periodic query scheduler modules.
package pqs_pkg;

    localparam int DUE_W = 48;
    localparam int ID_W  = 32;
    localparam int PER_W = 16;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_REG   = 2'd1;
    localparam logic [1:0] FUNC_NEXT  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [ID_W-1:0]  user_id;
        logic [PER_W-1:0] period;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] next_id;
        logic [1:0]      status;
    } t_rsp;

    typedef struct packed {
        logic [DUE_W-1:0] due;
        logic [ID_W-1:0]  id;
        logic [PER_W-1:0] period;
    } t_entry;

    typedef struct packed {
        logic pop;
        logic ins;
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE,
        S_INS
    } t_state;

endpackage

[rtl/core/periodic_query_scheduler.sv]
// Periodic query scheduler: a row of cells kept sorted by due time, id and slot.
//
// The store is a row of MAX_USERS cells ordered by (due time, id, registration slot),
// so the entry to serve always sits in the first cell. Clear and register requests
// are handled in S_IDLE: register inserts into every cell at once through a per-cell
// compare. A next request first pops the head cell in S_IDLE and shifts the row
// left while the advanced due time is computed; in S_INS it then reinserts the
// entry. The response for every request is held in an output register; a new
// request is taken when the scheduler is not reinserting and that register is free
// or being drained in the same cycle. No clearing pass is needed after reset.
module periodic_query_scheduler #(
    parameter int MAX_USERS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  pqs_pkg::t_req   i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output pqs_pkg::t_rsp   o_rsp
);

    localparam int IDX_W = $clog2(MAX_USERS);
    localparam int CNT_W = $clog2(MAX_USERS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_USERS);

    pqs_pkg::t_state    r_state;
    pqs_pkg::t_state    n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_rsp_valid;
    logic               n_rsp_valid;
    pqs_pkg::t_rsp      r_rsp;
    pqs_pkg::t_rsp      n_rsp;
    pqs_pkg::t_entry    r_ins_ent;
    pqs_pkg::t_entry    n_ins_ent;
    logic [IDX_W-1:0]   r_ins_idx;
    logic [IDX_W-1:0]   n_ins_idx;

    pqs_pkg::t_cell_ctl cell_ctl;
    pqs_pkg::t_entry    ins_ent;
    logic [IDX_W-1:0]   ins_idx;
    logic               req_acc;
    logic [pqs_pkg::DUE_W:0] due_sum;

    pqs_pkg::t_entry    cell_ent [MAX_USERS];
    logic [IDX_W-1:0]   cell_idx [MAX_USERS];
    logic               cell_lt  [MAX_USERS];

    assign o_req_stall = (r_state != pqs_pkg::S_IDLE) || (r_rsp_valid && i_rsp_stall);
    assign req_acc     = i_req_valid && !o_req_stall;

    assign due_sum = {1'b0, cell_ent[0].due} +
                     {{(pqs_pkg::DUE_W + 1 - pqs_pkg::PER_W){1'b0}}, cell_ent[0].period};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        n_ins_ent   = r_ins_ent;
        n_ins_idx   = r_ins_idx;
        cell_ctl    = '0;
        ins_ent     = r_ins_ent;
        ins_idx     = r_ins_idx;
        unique case (r_state)
            pqs_pkg::S_IDLE: begin
                ins_ent.due    = {{(pqs_pkg::DUE_W - pqs_pkg::PER_W){1'b0}}, i_req.period};
                ins_ent.id     = i_req.user_id;
                ins_ent.period = i_req.period;
                ins_idx        = r_cnt[IDX_W-1:0];
                if (req_acc) begin
                    n_rsp_valid    = 1'b1;
                    n_rsp.next_id  = '0;
                    n_rsp.status   = pqs_pkg::ST_OK;
                    unique case (i_req.func)
                        pqs_pkg::FUNC_CLEAR: begin
                            n_cnt = '0;
                        end
                        pqs_pkg::FUNC_REG: begin
                            if (r_cnt == CNT_FULL) begin
                                n_rsp.status = pqs_pkg::ST_FULL;
                            end else begin
                                cell_ctl.ins = 1'b1;
                                n_cnt        = r_cnt + CNT_W'(1);
                            end
                        end
                        pqs_pkg::FUNC_NEXT: begin
                            if (r_cnt == '0) begin
                                n_rsp.status = pqs_pkg::ST_EMPTY;
                            end else begin
                                cell_ctl.pop  = 1'b1;
                                n_cnt         = r_cnt - CNT_W'(1);
                                n_rsp.next_id = cell_ent[0].id;
                                n_ins_ent     = cell_ent[0];
                                n_ins_idx     = cell_idx[0];
                                if (due_sum[pqs_pkg::DUE_W]) begin
                                    n_ins_ent.due = '1;
                                    n_rsp.status  = pqs_pkg::ST_SAT;
                                end else begin
                                    n_ins_ent.due = due_sum[pqs_pkg::DUE_W-1:0];
                                end
                                n_state = pqs_pkg::S_INS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pqs_pkg::S_INS: begin
                cell_ctl.ins = 1'b1;
                n_cnt        = r_cnt + CNT_W'(1);
                n_state      = pqs_pkg::S_IDLE;
            end
            default: begin
                n_state = pqs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pqs_pkg::S_IDLE;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp     <= n_rsp;
        r_ins_ent <= n_ins_ent;
        r_ins_idx <= n_ins_idx;
    end

    for (genvar g = 0; g < MAX_USERS; g++) begin : g_cell
        logic               occ;
        logic               prev_lt;
        pqs_pkg::t_entry    prev_ent;
        logic [IDX_W-1:0]   prev_idx;
        pqs_pkg::t_entry    next_ent;
        logic [IDX_W-1:0]   next_idx;

        assign occ = CNT_W'(g) < r_cnt;

        if (g == 0) begin : g_first
            assign prev_lt  = 1'b0;
            assign prev_ent = ins_ent;
            assign prev_idx = ins_idx;
        end else begin : g_mid
            assign prev_lt  = cell_lt[g-1];
            assign prev_ent = cell_ent[g-1];
            assign prev_idx = cell_idx[g-1];
        end

        if (g == MAX_USERS - 1) begin : g_last
            assign next_ent = cell_ent[g];
            assign next_idx = cell_idx[g];
        end else begin : g_inner
            assign next_ent = cell_ent[g+1];
            assign next_idx = cell_idx[g+1];
        end

        pqs_cell #(
            .IDX_W(IDX_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_occ      (occ),
            .i_ctl      (cell_ctl),
            .i_ins_ent  (ins_ent),
            .i_ins_idx  (ins_idx),
            .i_prev_lt  (prev_lt),
            .i_prev_ent (prev_ent),
            .i_prev_idx (prev_idx),
            .i_next_ent (next_ent),
            .i_next_idx (next_idx),
            .o_lt       (cell_lt[g]),
            .o_ent      (cell_ent[g]),
            .o_idx      (cell_idx[g])
        );
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

[rtl/core/pqs_cell.sv]
// One cell of the sorted scheduling row: holds one entry, shifts or takes an insert.
module pqs_cell #(
    parameter int IDX_W = 6
) (
    input  logic               i_clk,
    input  logic               i_occ,
    input  pqs_pkg::t_cell_ctl i_ctl,
    input  pqs_pkg::t_entry    i_ins_ent,
    input  logic [IDX_W-1:0]   i_ins_idx,
    input  logic               i_prev_lt,
    input  pqs_pkg::t_entry    i_prev_ent,
    input  logic [IDX_W-1:0]   i_prev_idx,
    input  pqs_pkg::t_entry    i_next_ent,
    input  logic [IDX_W-1:0]   i_next_idx,
    output logic               o_lt,
    output pqs_pkg::t_entry    o_ent,
    output logic [IDX_W-1:0]   o_idx
);

    pqs_pkg::t_entry  r_ent;
    pqs_pkg::t_entry  n_ent;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;

    assign o_lt = !i_occ ||
        ({i_ins_ent.due, i_ins_ent.id, i_ins_idx} < {r_ent.due, r_ent.id, r_idx});

    always_comb begin
        n_ent = r_ent;
        n_idx = r_idx;
        if (i_ctl.pop) begin
            n_ent = i_next_ent;
            n_idx = i_next_idx;
        end else if (i_ctl.ins && o_lt) begin
            if (i_prev_lt) begin
                n_ent = i_prev_ent;
                n_idx = i_prev_idx;
            end else begin
                n_ent = i_ins_ent;
                n_idx = i_ins_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        r_idx <= n_idx;
    end

    assign o_ent = r_ent;
    assign o_idx = r_idx;

endmodule

[rtl/core/pqs_checker.sv]
// Port-level checks for the periodic query scheduler and their binding.
module pqs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_stall,
    input pqs_pkg::t_req i_req,
    input logic          o_rsp_valid,
    input logic          i_rsp_stall,
    input pqs_pkg::t_rsp o_rsp
);

    logic req_acc;
    assign req_acc = i_req_valid && !o_req_stall;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    a_clear_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && i_req.func == pqs_pkg::FUNC_CLEAR |=>
            o_rsp_valid && o_rsp.next_id == '0 && o_rsp.status == pqs_pkg::ST_OK)
        else $error("bad clear response");

    a_reg_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && i_req.func == pqs_pkg::FUNC_REG |=>
            o_rsp_valid && o_rsp.next_id == '0 &&
            (o_rsp.status == pqs_pkg::ST_OK || o_rsp.status == pqs_pkg::ST_FULL))
        else $error("bad register response");

    a_next_reinsert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && i_req.func == pqs_pkg::FUNC_NEXT |=>
            o_rsp_valid && (o_rsp.status == pqs_pkg::ST_EMPTY || o_req_stall))
        else $error("next request did not hold off for reinsert");

    a_empty_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && i_req.func == pqs_pkg::FUNC_CLEAR ##1
            req_acc && i_req.func == pqs_pkg::FUNC_NEXT |=>
            o_rsp.status == pqs_pkg::ST_EMPTY && o_rsp.next_id == '0)
        else $error("next after clear not empty");

endmodule

bind periodic_query_scheduler pqs_checker u_pqs_checker (.*);
